### src/ihx_pkg.sv
package ihx_pkg;

    // Framing and protocol constants, all as 16-bit lengths or exact field widths.
    localparam logic [15:0] ETH_HDR_BYTES     = 16'd14;
    localparam logic [15:0] IP_HDR_MIN_BYTES  = 16'd20;
    localparam logic [15:0] TCP_HDR_MIN_BYTES = 16'd20;
    localparam logic [15:0] UDP_HDR_SIZE      = 16'd8;
    localparam logic [15:0] ETHTYPE_IP4       = 16'h0800;
    localparam logic [3:0]  IP_VERSION_4      = 4'd4;
    localparam logic [7:0]  PROTO_TCP         = 8'd6;
    localparam logic [7:0]  PROTO_UDP         = 8'd17;

    // Byte positions of the ethertype within the Ethernet header.
    localparam logic [15:0] ETH_TYPE_HI_IDX = 16'd12;
    localparam logic [15:0] ETH_TYPE_LO_IDX = 16'd13;

    // Byte positions within the IPv4 header.
    localparam logic [15:0] IP_VER_IHL_OFS  = 16'd0;
    localparam logic [15:0] IP_LEN_HI_OFS   = 16'd2;
    localparam logic [15:0] IP_LEN_LO_OFS   = 16'd3;
    localparam logic [15:0] IP_PROTO_OFS    = 16'd9;
    localparam logic [15:0] IP_SRC_FIRST    = 16'd12;
    localparam logic [15:0] IP_SRC_LAST     = 16'd15;
    localparam logic [15:0] IP_DST_FIRST    = 16'd16;
    localparam logic [15:0] IP_DST_LAST     = 16'd19;

    // Byte positions within the transport header.
    localparam logic [15:0] L4_SPORT_HI_OFS = 16'd0;
    localparam logic [15:0] L4_SPORT_LO_OFS = 16'd1;
    localparam logic [15:0] L4_DPORT_HI_OFS = 16'd2;
    localparam logic [15:0] L4_DPORT_LO_OFS = 16'd3;
    localparam logic [15:0] L4_ULEN_HI_OFS  = 16'd4;
    localparam logic [15:0] L4_ULEN_LO_OFS  = 16'd5;
    localparam logic [15:0] L4_TCP_DOFF_OFS = 16'd12;

    localparam logic [15:0] BYTE_COUNT_MAX  = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_ETHERTYPE = 3'd2,
        ST_VERSION   = 3'd3,
        ST_IHL       = 3'd4,
        ST_TCP_HDR   = 3'd5,
        ST_PROTO     = 3'd6
    } status_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_item_t;

    typedef struct packed {
        logic [15:0] byte_count;
        logic [15:0] ether_kind;
        logic [3:0]  ip_version;
        logic [5:0]  ip_hdr_bytes;
        logic [15:0] ip_total_len;
        logic [7:0]  ip_proto;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [15:0] udp_len;
        logic [5:0]  tcp_hdr_bytes;
    } frame_t;

    typedef struct packed {
        status_t     status;
        logic        is_udp;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [15:0] payload_len;
    } result_t;

endpackage

### src/ihx_in_stage.sv
module ihx_in_stage
    import ihx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  byte_item_t in_item,
    input  logic       out_free,
    output logic       stall,
    output logic       advance,
    output byte_item_t item
);

    logic       valid_reg;
    logic       valid_next;
    byte_item_t item_reg;
    logic       accept;

    // A held byte moves on unless it closes a frame and the result register is full.
    assign advance = valid_reg & (~item_reg.last | out_free);
    assign stall   = valid_reg & ~advance;
    assign accept  = in_valid & ~stall;
    assign item    = item_reg;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    // Valid flag of the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Byte payload is loaded on every transfer.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

endmodule

### src/ihx_frame_state.sv
module ihx_frame_state
    import ihx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       link_type,
    input  logic       step,
    input  byte_item_t item,
    output frame_t     frame_next
);

    frame_t      frame_reg;
    logic [15:0] idx;
    logic [15:0] off;
    logic [15:0] r;
    logic [15:0] t;
    logic [15:0] ihl16;
    logic [7:0]  b;

    assign idx   = frame_reg.byte_count;
    assign b     = item.data;
    assign off   = link_type ? 16'd0 : ETH_HDR_BYTES;
    assign r     = idx - off;
    assign ihl16 = {10'd0, frame_reg.ip_hdr_bytes};
    assign t     = r - ihl16;

    // Place the current byte into whichever header field its offset selects.
    always_comb
    begin
        frame_next = frame_reg;

        if (!link_type && idx == ETH_TYPE_HI_IDX)
        begin
            frame_next.ether_kind[15:8] = b;
        end
        if (!link_type && idx == ETH_TYPE_LO_IDX)
        begin
            frame_next.ether_kind[7:0] = b;
        end

        if (idx >= off)
        begin
            if (r == IP_VER_IHL_OFS)
            begin
                frame_next.ip_version   = b[7:4];
                frame_next.ip_hdr_bytes = {b[3:0], 2'b00};
            end
            else if (r == IP_LEN_HI_OFS)
            begin
                frame_next.ip_total_len[15:8] = b;
            end
            else if (r == IP_LEN_LO_OFS)
            begin
                frame_next.ip_total_len[7:0] = b;
            end
            else if (r == IP_PROTO_OFS)
            begin
                frame_next.ip_proto = b;
            end
            else if (r >= IP_SRC_FIRST && r <= IP_SRC_LAST)
            begin
                frame_next.src_addr = {frame_reg.src_addr[23:0], b};
            end
            else if (r >= IP_DST_FIRST && r <= IP_DST_LAST)
            begin
                frame_next.dst_addr = {frame_reg.dst_addr[23:0], b};
            end

            // Transport bytes start right after the real IP header.
            if (ihl16 >= IP_HDR_MIN_BYTES && r >= ihl16)
            begin
                if (t == L4_SPORT_HI_OFS)
                begin
                    frame_next.src_port[15:8] = b;
                end
                else if (t == L4_SPORT_LO_OFS)
                begin
                    frame_next.src_port[7:0] = b;
                end
                else if (t == L4_DPORT_HI_OFS)
                begin
                    frame_next.dst_port[15:8] = b;
                end
                else if (t == L4_DPORT_LO_OFS)
                begin
                    frame_next.dst_port[7:0] = b;
                end
                else if (t == L4_ULEN_HI_OFS)
                begin
                    frame_next.udp_len[15:8] = b;
                end
                else if (t == L4_ULEN_LO_OFS)
                begin
                    frame_next.udp_len[7:0] = b;
                end
                else if (t == L4_TCP_DOFF_OFS)
                begin
                    frame_next.tcp_hdr_bytes = {b[7:4], 2'b00};
                end
            end
        end

        // The byte counter stops at its maximum.
        if (idx != BYTE_COUNT_MAX)
        begin
            frame_next.byte_count = idx + 16'd1;
        end
    end

    // Frame state advances per byte and clears after the closing byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= '0;
        end
        else if (step)
        begin
            if (item.last)
            begin
                frame_reg <= '0;
            end
            else
            begin
                frame_reg <= frame_next;
            end
        end
    end

endmodule

### src/ihx_judge.sv
module ihx_judge
    import ihx_pkg::*;
(
    input  logic    link_type,
    input  frame_t  frame,
    output result_t result
);

    logic [15:0] len;
    logic [15:0] off;
    logic [15:0] ihl16;
    logic [15:0] tcp16;
    status_t     st;
    logic        udp;
    logic [15:0] payload;

    assign len   = frame.byte_count;
    assign off   = link_type ? 16'd0 : ETH_HDR_BYTES;
    assign ihl16 = {10'd0, frame.ip_hdr_bytes};
    assign tcp16 = {10'd0, frame.tcp_hdr_bytes};

    // Checks run in priority order; the first failure sets the drop reason.
    always_comb
    begin
        st      = ST_OK;
        udp     = 1'b0;
        payload = 16'd0;
        if (!link_type && len < ETH_HDR_BYTES)
        begin
            st = ST_SHORT;
        end
        else if (!link_type && frame.ether_kind != ETHTYPE_IP4)
        begin
            st = ST_ETHERTYPE;
        end
        else if (len < off + IP_HDR_MIN_BYTES)
        begin
            st = ST_SHORT;
        end
        else if (frame.ip_version != IP_VERSION_4)
        begin
            st = ST_VERSION;
        end
        else if (ihl16 < IP_HDR_MIN_BYTES)
        begin
            st = ST_IHL;
        end
        else if (frame.ip_proto == PROTO_TCP)
        begin
            if (len < off + ihl16 + TCP_HDR_MIN_BYTES)
            begin
                st = ST_SHORT;
            end
            else if (tcp16 < TCP_HDR_MIN_BYTES)
            begin
                st = ST_TCP_HDR;
            end
            else
            begin
                payload = frame.ip_total_len - (ihl16 + tcp16);
            end
        end
        else if (frame.ip_proto == PROTO_UDP)
        begin
            if (len < off + ihl16 + UDP_HDR_SIZE)
            begin
                st = ST_SHORT;
            end
            else
            begin
                udp     = 1'b1;
                payload = frame.udp_len - UDP_HDR_SIZE;
            end
        end
        else
        begin
            st = ST_PROTO;
        end
    end

    // A dropped frame reports zeros in every field but the status.
    always_comb
    begin
        result        = '0;
        result.status = st;
        if (st == ST_OK)
        begin
            result.is_udp      = udp;
            result.src_addr    = frame.src_addr;
            result.dst_addr    = frame.dst_addr;
            result.src_port    = frame.src_port;
            result.dst_port    = frame.dst_port;
            result.payload_len = payload;
        end
    end

endmodule

### src/ipv4_l4_header_extractor_unit.sv
// Channel   Handshake             Payload
// -------   -------------------   ---------------------------------------------
// in        in_valid / in_stall   data_byte, last_byte
// out       out_valid / out_stall status, is_udp, src_addr, dst_addr,
//                                 src_port, dst_port, payload_len
// cfg       cfg_valid / cfg_ready link_type
//
// One byte is taken per cycle while in_stall is low; each byte passes through the input register.
// The closing byte's result is loaded at the edge where that byte leaves the input
// register, which a full result register can delay, and out_valid rises with that load.
// Reset clears the link type, the frame state and both valid flags.
// in_stall rises only while a closing byte waits behind an unaccepted result.
module ipv4_l4_header_extractor_unit
    import ihx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic        is_udp,
    output logic [31:0] src_addr,
    output logic [31:0] dst_addr,
    output logic [15:0] src_port,
    output logic [15:0] dst_port,
    output logic [15:0] payload_len,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        link_type
);

    logic       link_type_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    result_reg;
    result_t    result_next;
    byte_item_t in_item;
    byte_item_t item;
    frame_t     frame_next;
    logic       out_free;
    logic       advance;
    logic       load;

    assign in_item.data = data_byte;
    assign in_item.last = last_byte;
    assign cfg_ready    = 1'b1;

    // Link type register; a transfer on the configuration channel writes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_type_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            link_type_reg <= link_type;
        end
    end

    ihx_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_item  (in_item),
        .out_free (out_free),
        .stall    (in_stall),
        .advance  (advance),
        .item     (item)
    );

    ihx_frame_state u_frame_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .link_type  (link_type_reg),
        .step       (advance),
        .item       (item),
        .frame_next (frame_next)
    );

    ihx_judge u_judge (
        .link_type (link_type_reg),
        .frame     (frame_next),
        .result    (result_next)
    );

    // Result register: filled by a closing byte, emptied by an output transfer.
    assign out_free = ~out_valid_reg | ~out_stall;
    assign load     = advance & item.last;

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = result_reg.status;
    assign is_udp      = result_reg.is_udp;
    assign src_addr    = result_reg.src_addr;
    assign dst_addr    = result_reg.dst_addr;
    assign src_port    = result_reg.src_port;
    assign dst_port    = result_reg.dst_port;
    assign payload_len = result_reg.payload_len;

endmodule

### src/ihx_checker.sv
module ihx_checker
    import ihx_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  status,
    input logic        is_udp,
    input logic [31:0] src_addr,
    input logic [31:0] dst_addr,
    input logic [15:0] src_port,
    input logic [15:0] dst_port,
    input logic [15:0] payload_len
);

    // The input side is held back only by a result waiting at the output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a pending result");

    // A dropped frame carries only its drop reason.
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |->
        (is_udp == 1'b0 && src_addr == 32'd0 && dst_addr == 32'd0 &&
         src_port == 16'd0 && dst_port == 16'd0 && payload_len == 16'd0))
        else $error("dropped frame shows nonzero fields");

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result does not change.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
        ($stable(status) && $stable(src_addr) && $stable(dst_addr) &&
         $stable(src_port) && $stable(dst_port) && $stable(payload_len)))
        else $error("result changed while stalled");

endmodule

bind ipv4_l4_header_extractor_unit ihx_checker u_ihx_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .is_udp      (is_udp),
    .src_addr    (src_addr),
    .dst_addr    (dst_addr),
    .src_port    (src_port),
    .dst_port    (dst_port),
    .payload_len (payload_len)
);

### tb/frame_check_pkg.sv
`timescale 1ns / 100ps

package frame_check_pkg;

    import ihx_pkg::*;

    // Tracks one frame's captured header fields and queues the result each closing byte yields.
    class frame_scoreboard;

        bit        link_raw;
        bit [15:0] byte_count;
        bit [15:0] ether_kind;
        bit [3:0]  ip_version;
        bit [5:0]  ip_hdr_bytes;
        bit [15:0] ip_total_len;
        bit [7:0]  ip_proto;
        bit [31:0] src_addr;
        bit [31:0] dst_addr;
        bit [15:0] src_port;
        bit [15:0] dst_port;
        bit [15:0] udp_len;
        bit [5:0]  tcp_hdr_bytes;

        result_t   expected_q[$];
        int        errors;
        int        predicted;
        int        checked;
        int        status_seen[7];

        function new();
            link_raw = 1'b0;
            clear_frame();
        endfunction

        function void clear_frame();
            byte_count    = '0;
            ether_kind    = '0;
            ip_version    = '0;
            ip_hdr_bytes  = '0;
            ip_total_len  = '0;
            ip_proto      = '0;
            src_addr      = '0;
            dst_addr      = '0;
            src_port      = '0;
            dst_port      = '0;
            udp_len       = '0;
            tcp_hdr_bytes = '0;
        endfunction

        // Places one byte by its position in the frame, using the current link type.
        function void place_byte(bit [15:0] idx, bit [7:0] b);
            int pos;
            int r;
            int t;
            int off;
            pos = int'(idx);
            off = link_raw ? 0 : int'(ETH_HDR_BYTES);
            if (!link_raw && pos == int'(ETH_TYPE_HI_IDX))
                ether_kind[15:8] = b;
            if (!link_raw && pos == int'(ETH_TYPE_LO_IDX))
                ether_kind[7:0] = b;
            if (pos < off)
                return;
            r = pos - off;
            if (r == 0)
            begin
                ip_version   = b[7:4];
                ip_hdr_bytes = {b[3:0], 2'b00};
            end
            else if (r == 2)
                ip_total_len[15:8] = b;
            else if (r == 3)
                ip_total_len[7:0] = b;
            else if (r == 9)
                ip_proto = b;
            else if (r >= 12 && r <= 15)
                src_addr = {src_addr[23:0], b};
            else if (r >= 16 && r <= 19)
                dst_addr = {dst_addr[23:0], b};

            // Transport bytes count from the end of the real IP header, when that is valid.
            if (int'(ip_hdr_bytes) >= int'(IP_HDR_MIN_BYTES) && r >= int'(ip_hdr_bytes))
            begin
                t = r - int'(ip_hdr_bytes);
                case (t)
                    0: src_port[15:8] = b;
                    1: src_port[7:0]  = b;
                    2: dst_port[15:8] = b;
                    3: dst_port[7:0]  = b;
                    4: udp_len[15:8]  = b;
                    5: udp_len[7:0]   = b;
                    12: tcp_hdr_bytes = {b[7:4], 2'b00};
                    default: ;
                endcase
            end
        endfunction

        // Runs the frame checks in their fixed order.
        function status_t frame_status(output bit is_udp, output bit [15:0] payload);
            int len;
            int off;
            len     = int'(byte_count);
            off     = 0;
            is_udp  = 1'b0;
            payload = '0;
            if (!link_raw)
            begin
                if (len < int'(ETH_HDR_BYTES))
                    return ST_SHORT;
                if (ether_kind != ETHTYPE_IP4)
                    return ST_ETHERTYPE;
                off = int'(ETH_HDR_BYTES);
            end
            if (len < off + int'(IP_HDR_MIN_BYTES))
                return ST_SHORT;
            if (ip_version != IP_VERSION_4)
                return ST_VERSION;
            if (int'(ip_hdr_bytes) < int'(IP_HDR_MIN_BYTES))
                return ST_IHL;
            if (ip_proto == PROTO_TCP)
            begin
                if (len < off + int'(ip_hdr_bytes) + int'(TCP_HDR_MIN_BYTES))
                    return ST_SHORT;
                if (int'(tcp_hdr_bytes) < int'(TCP_HDR_MIN_BYTES))
                    return ST_TCP_HDR;
                payload = ip_total_len - (16'(ip_hdr_bytes) + 16'(tcp_hdr_bytes));
                return ST_OK;
            end
            if (ip_proto == PROTO_UDP)
            begin
                if (len < off + int'(ip_hdr_bytes) + int'(UDP_HDR_SIZE))
                    return ST_SHORT;
                is_udp  = 1'b1;
                payload = udp_len - UDP_HDR_SIZE;
                return ST_OK;
            end
            return ST_PROTO;
        endfunction

        // Notes an accepted byte; a closing byte queues its expected result.
        function void note_byte(bit [7:0] b, bit last);
            result_t   exp;
            bit        is_udp;
            bit [15:0] payload;
            place_byte(byte_count, b);
            if (byte_count != BYTE_COUNT_MAX)
                byte_count++;
            if (!last)
                return;
            exp = '0;
            exp.status = frame_status(is_udp, payload);
            if (exp.status == ST_OK)
            begin
                exp.is_udp      = is_udp;
                exp.src_addr    = src_addr;
                exp.dst_addr    = dst_addr;
                exp.src_port    = src_port;
                exp.dst_port    = dst_port;
                exp.payload_len = payload;
            end
            status_seen[int'(exp.status)]++;
            predicted++;
            expected_q = {expected_q, exp};
            clear_frame();
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            end
        endfunction

        // Checks one transferred result against the oldest pending frame.
        function void check_result(logic [2:0] st, logic u, logic [31:0] sa, logic [31:0] da,
                                   logic [15:0] sp, logic [15:0] dp, logic [15:0] pl);
            result_t exp;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: result with no frame pending, expected none, got status %0d",
                         $time, st);
                return;
            end
            exp = expected_q.pop_front();
            checked++;
            compare_field("status", 32'(exp.status), 32'(st));
            compare_field("is_udp", 32'(exp.is_udp), 32'(u));
            compare_field("src_addr", exp.src_addr, sa);
            compare_field("dst_addr", exp.dst_addr, da);
            compare_field("src_port", 32'(exp.src_port), 32'(sp));
            compare_field("dst_port", 32'(exp.dst_port), 32'(dp));
            compare_field("payload_len", 32'(exp.payload_len), 32'(pl));
        endfunction

    endclass

endpackage

### tb/tb.sv
`timescale 1ns / 100ps

module tb;

    import ihx_pkg::*;
    import frame_check_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    // Header layout of one generated frame; fields are placed as given, even when invalid.
    typedef struct {
        bit        raw;
        bit [15:0] eth_kind;
        bit [3:0]  version;
        bit [3:0]  ihl_words;
        bit [15:0] total_len;
        bit [7:0]  proto;
        bit [3:0]  doff_words;
        bit [15:0] udp_len;
        int        body_len;
        int        cut_len;
    } frame_spec_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = '0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic        is_udp;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] payload_len;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        link_type = 1'b0;

    frame_scoreboard sb;
    bit              calm = 1'b0;
    int              byte_total = 0;
    int              frame_total = 0;
    int              idle_cycles = 0;
    int              stall_left = 0;

    ipv4_l4_header_extractor_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .is_udp      (is_udp),
        .src_addr    (src_addr),
        .dst_addr    (dst_addr),
        .src_port    (src_port),
        .dst_port    (dst_port),
        .payload_len (payload_len),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .link_type   (link_type)
    );

    initial
    begin
        forever
            #2 clk = ~clk;
    end

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Receiver stalls the result channel in random bursts.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            stall_left = pick_gap();
        end
    end

    // Every result transfer is checked against the predicted queue.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(status, is_udp, src_addr, dst_addr, src_port, dst_port,
                            payload_len);
    end

    // Count cycles with no transfer on any channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("Watchdog expired after %0d cycles without a transfer", IDLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // Sends one byte, after an optional gap, and waits for its transfer.
    task automatic send_byte(input bit [7:0] d, input bit last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= d;
        last_byte <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_byte(d, last);
        byte_total++;
        if (last)
            frame_total++;
    endtask

    // Holds the sender off until all results are back and the pipeline has emptied.
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (sb.expected_q.size() > 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_link_type(input bit raw);
        wait_quiet();
        cfg_valid <= 1'b1;
        link_type <= raw;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.link_raw = raw;
    endtask

    task automatic send_noise(input int n, input bit fixed, input bit [7:0] fill);
        for (int i = 0; i < n; i++)
            send_byte(fixed ? fill : 8'($urandom), i == n - 1);
    endtask

    function automatic frame_spec_t sane_spec(input bit raw);
        frame_spec_t s;
        int          l4;
        s.raw        = raw;
        s.eth_kind   = ETHTYPE_IP4;
        s.version    = IP_VERSION_4;
        s.ihl_words  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
        s.proto      = $urandom_range(0, 1) ? PROTO_UDP : PROTO_TCP;
        s.doff_words = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
        s.body_len   = $urandom_range(0, 40);
        l4           = (s.proto == PROTO_TCP) ? s.doff_words * 4 : int'(UDP_HDR_SIZE);
        s.total_len  = 16'(s.ihl_words * 4 + l4 + s.body_len);
        s.udp_len    = 16'(int'(UDP_HDR_SIZE) + s.body_len);
        s.cut_len    = 0;
        return s;
    endfunction

    // Builds the frame bytes from a spec, optionally truncates, and sends them.
    task automatic send_frame(input frame_spec_t s);
        bit [7:0] fb[$];
        bit [7:0] v;
        int       ip_len;
        int       l4_len;
        bit       is_tcp;
        bit       is_udp_frame;
        is_tcp       = (s.proto == PROTO_TCP);
        is_udp_frame = (s.proto == PROTO_UDP);
        if (!s.raw)
        begin
            for (int i = 0; i < 12; i++)
            begin
                v  = 8'($urandom);
                fb = {fb, v};
            end
            v  = s.eth_kind[15:8];
            fb = {fb, v};
            v  = s.eth_kind[7:0];
            fb = {fb, v};
        end
        // An undersized header length still gets the fixed 20 header bytes.
        ip_len = (s.ihl_words >= 5) ? s.ihl_words * 4 : int'(IP_HDR_MIN_BYTES);
        for (int i = 0; i < ip_len; i++)
        begin
            case (i)
                0: v = {s.version, s.ihl_words};
                2: v = s.total_len[15:8];
                3: v = s.total_len[7:0];
                9: v = s.proto;
                default: v = 8'($urandom);
            endcase
            fb = {fb, v};
        end
        if (is_tcp)
            l4_len = (s.doff_words > 5) ? s.doff_words * 4 : int'(TCP_HDR_MIN_BYTES);
        else
            l4_len = int'(UDP_HDR_SIZE);
        for (int i = 0; i < l4_len; i++)
        begin
            if (is_udp_frame && i == 4)
                v = s.udp_len[15:8];
            else if (is_udp_frame && i == 5)
                v = s.udp_len[7:0];
            else if (is_tcp && i == 12)
                v = {s.doff_words, 4'($urandom)};
            else
                v = 8'($urandom);
            fb = {fb, v};
        end
        for (int i = 0; i < s.body_len; i++)
        begin
            v  = 8'($urandom);
            fb = {fb, v};
        end
        if (s.cut_len > 0)
            while (fb.size() > s.cut_len)
                void'(fb.pop_back());
        foreach (fb[i])
            send_byte(fb[i], i == fb.size() - 1);
    endtask

    // A frame with one field broken, a truncation, or the wrong framing.
    function automatic frame_spec_t broken_spec(input bit raw);
        frame_spec_t s;
        s = sane_spec(raw);
        case ($urandom_range(0, 8))
            0: s.eth_kind   = 16'($urandom);
            1: s.version    = 4'($urandom);
            2: s.ihl_words  = 4'($urandom_range(0, 4));
            3: s.proto      = 8'($urandom);
            4: s.doff_words = 4'($urandom);
            5: s.cut_len    = $urandom_range(1, 70);
            6: s.udp_len    = 16'($urandom);
            7: s.total_len  = 16'($urandom);
            default: s.raw  = !raw;
        endcase
        return s;
    endfunction

    initial
    begin
        frame_spec_t s;
        int          budget;
        int          phase_start;
        int          kind;
        bit          raw;

        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames with Ethernet framing.
        set_link_type(1'b0);
        send_byte(8'h00, 1'b1);
        s = sane_spec(1'b0); s.cut_len = 10; send_frame(s);
        s = sane_spec(1'b0); s.eth_kind = 16'h86DD; send_frame(s);
        s = sane_spec(1'b0); s.cut_len = 30; send_frame(s);
        s = sane_spec(1'b0); s.version = 4'd6; send_frame(s);
        s = sane_spec(1'b0); s.ihl_words = 4'd0; send_frame(s);
        s = sane_spec(1'b0); s.ihl_words = 4'd4; s.proto = PROTO_TCP; send_frame(s);
        s = sane_spec(1'b0); s.proto = PROTO_TCP; s.doff_words = 4'd5; s.ihl_words = 4'd5;
        s.body_len = 0; s.total_len = 16'd40; send_frame(s);
        s = sane_spec(1'b0); s.proto = PROTO_TCP; s.ihl_words = 4'd15; s.doff_words = 4'd15;
        s.body_len = 5; s.total_len = 16'hFFFF; send_frame(s);
        s = sane_spec(1'b0); s.proto = PROTO_TCP; s.ihl_words = 4'd5; s.cut_len = 53;
        send_frame(s);
        s = sane_spec(1'b0); s.proto = PROTO_TCP; s.doff_words = 4'd4; send_frame(s);
        s = sane_spec(1'b0); s.proto = PROTO_TCP; s.total_len = 16'd10; send_frame(s);
        s = sane_spec(1'b0); s.proto = PROTO_UDP; s.ihl_words = 4'd6; send_frame(s);
        s = sane_spec(1'b0); s.proto = PROTO_UDP; s.udp_len = 16'd3; send_frame(s);
        s = sane_spec(1'b0); s.proto = PROTO_UDP; s.ihl_words = 4'd5; s.cut_len = 41;
        send_frame(s);
        s = sane_spec(1'b0); s.proto = 8'd1; send_frame(s);
        send_noise(60, 1'b1, 8'hFF);
        send_noise(60, 1'b1, 8'h00);

        // Directed frames as raw IPv4.
        set_link_type(1'b1);
        send_byte(8'hFF, 1'b1);
        s = sane_spec(1'b1); s.proto = PROTO_TCP; send_frame(s);
        s = sane_spec(1'b1); s.proto = PROTO_UDP; s.udp_len = 16'hFFFF; send_frame(s);
        s = sane_spec(1'b1); s.cut_len = 19; send_frame(s);
        s = sane_spec(1'b1); s.version = 4'd15; send_frame(s);
        s = sane_spec(1'b1); s.proto = 8'hFF; send_frame(s);

        // Random phases, each under one link type, mostly well-formed frames.
        while (byte_total < 1900)
        begin
            raw = 1'($urandom_range(0, 1));
            set_link_type(raw);
            calm        = ($urandom_range(0, 3) == 0);
            budget      = $urandom_range(100, 250);
            phase_start = byte_total;
            while (byte_total - phase_start < budget)
            begin
                kind = $urandom_range(0, 9);
                if (kind < 7)
                    send_frame(sane_spec(raw));
                else if (kind < 9)
                    send_frame(broken_spec(raw));
                else
                    send_noise($urandom_range(1, 80), 1'b0, 8'h00);
            end
        end
        calm = 1'b0;

        // Drain and report.
        in_valid <= 1'b0;
        while (sb.expected_q.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("Sent %0d frames in %0d bytes over both link types; %0d results checked.",
                 frame_total, byte_total, sb.checked);
        $display("Results by status: ok %0d, short %0d, ethertype %0d, version %0d,",
                 sb.status_seen[ST_OK], sb.status_seen[ST_SHORT],
                 sb.status_seen[ST_ETHERTYPE], sb.status_seen[ST_VERSION]);
        $display("  ihl %0d, tcp header %0d, protocol %0d.",
                 sb.status_seen[ST_IHL], sb.status_seen[ST_TCP_HDR], sb.status_seen[ST_PROTO]);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
